>>> src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Every macro samples on the rising edge of a signal named clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/aatp_pkg.sv
// Shared constants and types of the AppleTalk address text parser.
// Used by the decoder, the parse core and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aatp_pkg;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_UC_A = 8'h41;
   localparam logic [7:0] CHAR_UC_F = 8'h46;
   localparam logic [7:0] CHAR_UC_X = 8'h58;
   localparam logic [7:0] CHAR_LC_A = 8'h61;
   localparam logic [7:0] CHAR_LC_F = 8'h66;
   localparam logic [7:0] CHAR_LC_X = 8'h78;

   localparam int NET_WIDTH  = 16;
   localparam int NODE_WIDTH = 8;
   localparam int ACC_WIDTH  = 32;

   // Hex letters a..f and A..F share their low three bits, offset by nine.
   localparam logic [3:0] LETTER_OFFSET = 4'd9;

   typedef struct packed {
      logic       is_nul;
      logic       is_dot;
      logic       is_zero;
      logic       is_x;
      logic       is_digit;
      logic       is_letter;
      logic [3:0] digit_val;
      logic [3:0] letter_val;
   } char_class_type;

   typedef struct packed {
      logic                  emit;
      logic                  valid_res;
      logic [NET_WIDTH-1:0]  net;
      logic [NODE_WIDTH-1:0] node;
   } step_result_type;

endpackage

`default_nettype wire

>>> src/aatp_if.sv
// Valid/ready channel interfaces of the AppleTalk address text parser.
// Response payload widths come from aatp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface aatp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface aatp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           valid_res;
   logic [aatp_pkg::NET_WIDTH-1:0]  net;
   logic [aatp_pkg::NODE_WIDTH-1:0] node;

   modport source (output valid, output valid_res, output net, output node, input ready);
   modport sink (input valid, input valid_res, input net, input node, output ready);
endinterface

`default_nettype wire

>>> src/aatp_char_decode.sv
// Character classifier: sorts one ASCII byte into the classes the parser needs.
// Depends on aatp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aatp_char_decode (
   input  wire logic [7:0]              char_code,
   output aatp_pkg::char_class_type     cls
);

   always_comb begin
      cls            = '0;
      cls.is_nul     = (char_code == aatp_pkg::CHAR_NUL);
      cls.is_dot     = (char_code == aatp_pkg::CHAR_DOT);
      cls.is_zero    = (char_code == aatp_pkg::CHAR_ZERO);
      cls.is_x       = (char_code == aatp_pkg::CHAR_LC_X) || (char_code == aatp_pkg::CHAR_UC_X);
      cls.is_digit   = char_code inside {[aatp_pkg::CHAR_ZERO:aatp_pkg::CHAR_NINE]};
      cls.is_letter  = char_code inside {[aatp_pkg::CHAR_LC_A:aatp_pkg::CHAR_LC_F],
                                         [aatp_pkg::CHAR_UC_A:aatp_pkg::CHAR_UC_F]};
      cls.digit_val  = char_code[3:0];
      cls.letter_val = {1'b0, char_code[2:0]} + aatp_pkg::LETTER_OFFSET;
   end

endmodule

`default_nettype wire

>>> src/aatp_parse_core.sv
// Parse state and per-character next-state logic of the address parser.
// Depends on aatp_pkg; fed by aatp_char_decode through the top level.
`timescale 1ns / 1ps
`default_nettype none

module aatp_parse_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  aatp_pkg::char_class_type       cls,
   output aatp_pkg::step_result_type      step
);

   typedef enum logic [1:0] {
      PH_START,
      PH_LEAD_ZERO,
      PH_FIELDS
   } phase_type;

   phase_type                             phase_ff, phase_in;
   logic                                  hex_ff, hex_in;
   logic [aatp_pkg::ACC_WIDTH-1:0]        accum_ff, accum_in;
   logic [1:0]                            field_ff, field_in;
   logic [aatp_pkg::NET_WIDTH-1:0]        net_ff, net_in;
   logic [aatp_pkg::NODE_WIDTH-1:0]       node_ff, node_in;
   logic                                  failed_ff, failed_in;

   logic                                  prefix_only;
   logic                                  bad;
   logic                                  clear;
   logic [aatp_pkg::NET_WIDTH-1:0]        net_t;
   logic [aatp_pkg::NODE_WIDTH-1:0]       node_t;
   logic                                  acc_over_net;
   logic                                  acc_over_node;

   assign acc_over_net  = |accum_ff[aatp_pkg::ACC_WIDTH-1:aatp_pkg::NET_WIDTH];
   assign acc_over_node = |accum_ff[aatp_pkg::ACC_WIDTH-1:aatp_pkg::NODE_WIDTH];

   always_comb begin
      phase_in    = phase_ff;
      hex_in      = hex_ff;
      accum_in    = accum_ff;
      field_in    = field_ff;
      net_in      = net_ff;
      node_in     = node_ff;
      failed_in   = failed_ff;
      step        = '0;
      prefix_only = 1'b0;
      bad         = 1'b0;
      clear       = 1'b0;
      net_t       = net_ff;
      node_t      = node_ff;

      if (failed_ff) begin
         // A failed string swallows everything up to its terminator.
         if (cls.is_nul) begin
            step.emit = 1'b1;
            clear     = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_START: begin
               if (cls.is_zero) begin
                  phase_in    = PH_LEAD_ZERO;
                  prefix_only = 1'b1;
               end else begin
                  if (cls.is_letter) hex_in = 1'b1;
                  phase_in = PH_FIELDS;
               end
            end
            PH_LEAD_ZERO: begin
               if (cls.is_x) begin
                  hex_in      = 1'b1;
                  phase_in    = PH_FIELDS;
                  prefix_only = 1'b1;
               end else begin
                  if (cls.is_letter) hex_in = 1'b1;
                  phase_in = PH_FIELDS;
               end
            end
            default: ;
         endcase

         if (!prefix_only) begin
            if (cls.is_digit) begin
               accum_in = hex_in ? ((accum_ff << 4) + 32'(cls.digit_val))
                                 : ((accum_ff << 3) + (accum_ff << 1) + 32'(cls.digit_val));
            end else if (hex_in && cls.is_letter) begin
               accum_in = (accum_ff << 4) + 32'(cls.letter_val);
            end else if (!cls.is_dot && !cls.is_nul) begin
               failed_in = 1'b1;
            end else begin
               // A dot or the terminator closes the current field.
               case (field_ff)
                  2'd0: begin
                     if (acc_over_net) bad = 1'b1;
                     else net_t = accum_ff[aatp_pkg::NET_WIDTH-1:0];
                  end
                  2'd1: begin
                     if (acc_over_node) bad = 1'b1;
                     else node_t = accum_ff[aatp_pkg::NODE_WIDTH-1:0];
                  end
                  2'd2: begin
                     if (acc_over_node || (|net_ff[aatp_pkg::NET_WIDTH-1:aatp_pkg::NODE_WIDTH])) begin
                        bad = 1'b1;
                     end else begin
                        net_t  = {net_ff[aatp_pkg::NODE_WIDTH-1:0], node_ff};
                        node_t = accum_ff[aatp_pkg::NODE_WIDTH-1:0];
                     end
                  end
                  default: bad = 1'b1;
               endcase

               if (bad) begin
                  if (cls.is_nul) begin
                     step.emit = 1'b1;
                     clear     = 1'b1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else if (cls.is_dot) begin
                  accum_in = '0;
                  field_in = field_ff + 2'd1;
                  net_in   = net_t;
                  node_in  = node_t;
               end else begin
                  step.emit      = 1'b1;
                  step.valid_res = (field_ff != 2'd0);
                  step.net       = (field_ff != 2'd0) ? net_t : '0;
                  step.node      = (field_ff != 2'd0) ? node_t : '0;
                  clear          = 1'b1;
               end
            end
         end
      end

      if (clear) begin
         phase_in  = PH_START;
         hex_in    = 1'b0;
         accum_in  = '0;
         field_in  = '0;
         net_in    = '0;
         node_in   = '0;
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         hex_ff    <= 1'b0;
         accum_ff  <= '0;
         field_ff  <= '0;
         net_ff    <= '0;
         node_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         hex_ff    <= hex_in;
         accum_ff  <= accum_in;
         field_ff  <= field_in;
         net_ff    <= net_in;
         node_ff   <= node_in;
         failed_ff <= failed_in;
      end
   end

endmodule

`default_nettype wire

>>> src/appletalk_address_text_parser.sv
// AppleTalk address text parser. Characters arrive one per transaction on the
// request channel; a zero byte ends the string and produces exactly one response
// carrying valid_res, net and node (net and node read zero when the text is not
// a valid "net.node" or "nethi.netlo.node" address). Every other character
// produces no response. The block takes one character per clock cycle unless
// stalled: a character is captured in an input register and parsed from there
// by the parse core, whose result for a terminator is held in the response
// register that drives the response channel. The only thing that slows the
// request channel is the response register: while it holds an untaken response
// and the next terminator is waiting behind it, req_chan.ready stays low.
// Depends on aatp_pkg, aatp_if, aatp_char_decode and aatp_parse_core.
`timescale 1ns / 1ps
`default_nettype none

module appletalk_address_text_parser (
   input  wire logic     clock,
   input  wire logic     reset,
   aatp_req_if.sink      req_chan,
   aatp_rsp_if.source    rsp_chan
);

   logic                              in_valid_ff, in_valid_in;
   logic [7:0]                        in_char_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_valid_res_ff;
   logic [aatp_pkg::NET_WIDTH-1:0]    rsp_net_ff;
   logic [aatp_pkg::NODE_WIDTH-1:0]   rsp_node_ff;

   aatp_pkg::char_class_type          cls;
   aatp_pkg::step_result_type         step;
   logic                              out_free;
   logic                              advance;
   logic                              req_take;

   aatp_char_decode u_decode (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   aatp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cls     (cls),
      .step    (step)
   );

   // A character that gives no response never waits for the response register.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && (!step.emit || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = out_free ? (advance && step.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_code;
      end
      if (advance && step.emit) begin
         rsp_valid_res_ff <= step.valid_res;
         rsp_net_ff       <= step.net;
         rsp_node_ff      <= step.node;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = rsp_valid_res_ff;
   assign rsp_chan.net       = rsp_net_ff;
   assign rsp_chan.node      = rsp_node_ff;

endmodule

`default_nettype wire

>>> src/aatp_checker.sv
// Port-level checker of the AppleTalk address text parser, bound to the top level.
// Depends on assert_macros.svh and aatp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aatp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [7:0]                        req_char_code,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_valid_res,
   input wire logic [aatp_pkg::NET_WIDTH-1:0]    rsp_net,
   input wire logic [aatp_pkg::NODE_WIDTH-1:0]   rsp_node
);

   // A stalled response keeps its payload.
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_valid_res) && $stable(rsp_net) && $stable(rsp_node)), "response changed while stalled")

   // A rejected address reports zero net and node.
   `ASSERT_CLK(a_invalid_zero, (rsp_valid && !rsp_valid_res) |-> (rsp_net == '0 && rsp_node == '0), "invalid response carries nonzero fields")

   // A fresh response follows a terminator taken on the request channel.
   `ASSERT_CLK(a_rsp_after_nul, $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_char_code == aatp_pkg::CHAR_NUL), 2), "response without a terminator")

   // With the response register empty, the input side never stalls.
   `ASSERT_CLK(a_ready_when_empty, !rsp_valid |-> req_ready, "request stalled with empty response register")

endmodule

bind appletalk_address_text_parser aatp_checker u_aatp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_char_code (req_chan.char_code),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_valid_res (rsp_chan.valid_res),
   .rsp_net       (rsp_chan.net),
   .rsp_node      (rsp_chan.node)
);

`default_nettype wire
